// File: hw/rtl/wpa_pkg.sv
// ----------------------------------------------------------------------------
// Worker pool autoscaler package
// Shared types, codes and constants of the pool scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package wpa_pkg;

  // Hard slot limit of the pool; the configured limit is clipped to it.
  localparam logic [6:0] MaxSlots = 7'd64;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_GROW   = 2'd1,
    PH_SHRINK = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_JOIN  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_MAX_WORKERS  = 3'd0,
    REG_LOW_USAGE    = 3'd1,
    REG_HIGH_USAGE   = 3'd2,
    REG_SHRINK_CEIL  = 3'd3,
    REG_SHRINK_POLLS = 3'd4,
    REG_GROW_STEP    = 3'd5
  } cfg_reg_e;

  localparam logic CMD_POLL  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic [6:0] max_workers;
    logic [9:0] low_usage_threshold;
    logic [9:0] high_usage_threshold;
    logic [9:0] shrink_ceiling;
    logic [7:0] shrink_after_polls;
    logic [6:0] grow_step_limit;
  } wpa_cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [6:0] active_count;
    logic [6:0] pending_change;
    logic [7:0] low_polls;
  } wpa_state_t;

  typedef struct packed {
    logic       command;
    logic [6:0] request_count;
    logic       usage_valid;
    logic [9:0] usage_tenths;
    logic       new_workers_running;
    logic       leaving_workers_stopped;
  } wpa_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] first_index;
    logic [6:0] action_count;
    logic [6:0] active_workers;
    logic [1:0] pool_phase;
    logic [7:0] low_load_count;
  } wpa_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/wpa_in_if.sv
// ----------------------------------------------------------------------------
// Autoscaler input channel
// Valid/ready channel carrying one poll or start request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpa_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [6:0] request_count;
  logic       usage_valid;
  logic [9:0] usage_tenths;
  logic       new_workers_running;
  logic       leaving_workers_stopped;

  modport source (
    output valid, command, request_count, usage_valid, usage_tenths,
           new_workers_running, leaving_workers_stopped,
    input  ready
  );

  modport sink (
    input  valid, command, request_count, usage_valid, usage_tenths,
           new_workers_running, leaving_workers_stopped,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/wpa_out_if.sv
// ----------------------------------------------------------------------------
// Autoscaler result channel
// Valid/ready channel carrying one scaling decision per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] first_index;
  logic [6:0] action_count;
  logic [6:0] active_workers;
  logic [1:0] pool_phase;
  logic [7:0] low_load_count;

  modport source (
    output valid, action, first_index, action_count, active_workers,
           pool_phase, low_load_count,
    input  ready
  );

  modport sink (
    input  valid, action, first_index, action_count, active_workers,
           pool_phase, low_load_count,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/worker_pool_autoscaler_core.sv
// Worker pool autoscaler core.
// An accepted input beat passes the input register, then the decision logic
// into the result register. The state update loop sets the throughput:
// one beat per cycle unless stalled by the result sink.
// Reset: idle phase, empty pool, counters cleared, registers at defaults.
// ----------------------------------------------------------------------------
// Worker pool autoscaler
// Grows and shrinks a worker pool from polled usage and start requests.
// ----------------------------------------------------------------------------
`default_nettype none

module worker_pool_autoscaler_core import wpa_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  wpa_in_if.sink          item_i,
  wpa_out_if.source       result_o
);

  // Configuration registers
  wpa_cfg_t    cfg_q;

  // Pipeline: input register, then result register
  logic        in_valid_q;
  wpa_item_t   item_q;
  logic        out_valid_q;
  wpa_result_t result_q;

  // Pool state
  wpa_state_t  state_q;
  wpa_state_t  state_d;
  wpa_result_t result_d;

  logic        advance;
  logic        in_fire;
  logic        step_fire;

  // Move a beat into the result register whenever it is free or drained.
  assign advance   = !out_valid_q || result_o.ready;
  assign item_i.ready = !in_valid_q || advance;
  assign in_fire   = item_i.valid && item_i.ready;
  assign step_fire = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_workers          <= 7'd16;
      cfg_q.low_usage_threshold  <= 10'd500;
      cfg_q.high_usage_threshold <= 10'd900;
      cfg_q.shrink_ceiling       <= 10'd700;
      cfg_q.shrink_after_polls   <= 8'd30;
      cfg_q.grow_step_limit      <= 7'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_WORKERS:  cfg_q.max_workers          <= cfg_data_i[6:0];
        REG_LOW_USAGE:    cfg_q.low_usage_threshold  <= cfg_data_i;
        REG_HIGH_USAGE:   cfg_q.high_usage_threshold <= cfg_data_i;
        REG_SHRINK_CEIL:  cfg_q.shrink_ceiling       <= cfg_data_i;
        REG_SHRINK_POLLS: cfg_q.shrink_after_polls   <= cfg_data_i[7:0];
        REG_GROW_STEP:    cfg_q.grow_step_limit      <= cfg_data_i[6:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Capture the input beat; payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.command                 <= item_i.command;
      item_q.request_count           <= item_i.request_count;
      item_q.usage_valid             <= item_i.usage_valid;
      item_q.usage_tenths            <= item_i.usage_tenths;
      item_q.new_workers_running     <= item_i.new_workers_running;
      item_q.leaving_workers_stopped <= item_i.leaving_workers_stopped;
    end
  end

  wpa_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Advance pool state once per processed beat, in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PH_IDLE;
      state_q.active_count   <= 7'd0;
      state_q.pending_change <= 7'd0;
      state_q.low_polls      <= 8'd0;
      out_valid_q            <= 1'b0;
    end else begin
      if (step_fire) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.action         = result_q.action;
  assign result_o.first_index    = result_q.first_index;
  assign result_o.action_count   = result_q.action_count;
  assign result_o.active_workers = result_q.active_workers;
  assign result_o.pool_phase     = result_q.pool_phase;
  assign result_o.low_load_count = result_q.low_load_count;

endmodule

`default_nettype wire

// File: hw/rtl/wpa_step.sv
// ----------------------------------------------------------------------------
// Autoscaler decision logic
// Next pool state and result for one beat, from current state and config.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_step import wpa_pkg::*; (
  input  wire wpa_cfg_t   cfg_i,
  input  wire wpa_state_t state_i,
  input  wire wpa_item_t  item_i,
  output wpa_state_t      state_o,
  output wpa_result_t     result_o
);

  logic [6:0]  limit;
  logic [6:0]  free_slots;
  logic [6:0]  start_k;
  logic [7:0]  half_sum;
  logic [6:0]  half_active;
  logic [6:0]  grow_n;
  logic [7:0]  polls_upd;
  logic [6:0]  active_m1;
  logic [16:0] proj_usage;
  logic [16:0] proj_ceil;
  logic        shrink_ok;
  logic [1:0]  act;
  logic [6:0]  first;
  logic [6:0]  cnt;

  always_comb begin
    limit      = (cfg_i.max_workers < MaxSlots) ? cfg_i.max_workers : MaxSlots;
    free_slots = (limit > state_i.active_count) ? limit - state_i.active_count : 7'd0;
    start_k    = (item_i.request_count < free_slots) ? item_i.request_count : free_slots;

    // ceil(active/2), then clip by step limit and free slots
    half_sum    = {1'b0, state_i.active_count} + 8'd1;
    half_active = half_sum[7:1];
    grow_n      = (cfg_i.grow_step_limit < half_active) ? cfg_i.grow_step_limit
                                                        : half_active;
    grow_n      = (free_slots < grow_n) ? free_slots : grow_n;

    if (item_i.usage_tenths > cfg_i.low_usage_threshold) begin
      polls_upd = 8'd0;
    end else if (state_i.low_polls != 8'hFF) begin
      polls_upd = state_i.low_polls + 8'd1;
    end else begin
      polls_upd = state_i.low_polls;
    end

    // usage*n < ceiling*(n-1)
    active_m1  = state_i.active_count - 7'd1;
    proj_usage = {7'd0, item_i.usage_tenths} * {10'd0, state_i.active_count};
    proj_ceil  = {7'd0, cfg_i.shrink_ceiling} * {10'd0, active_m1};
    shrink_ok  = (state_i.active_count >= 7'd2) && (proj_usage < proj_ceil);

    state_o = state_i;
    act     = ACT_NONE;
    first   = 7'd0;
    cnt     = 7'd0;

    if (item_i.command == CMD_START) begin
      if (state_i.phase == PH_IDLE && start_k != 7'd0) begin
        act                    = ACT_START;
        first                  = state_i.active_count;
        cnt                    = start_k;
        state_o.pending_change = start_k;
        state_o.phase          = PH_GROW;
      end
    end else begin
      case (state_i.phase)
        PH_GROW: begin
          if (item_i.new_workers_running) begin
            state_o.active_count   = state_i.active_count + state_i.pending_change;
            state_o.pending_change = 7'd0;
            state_o.phase          = PH_IDLE;
          end
        end
        PH_SHRINK: begin
          if (item_i.leaving_workers_stopped) begin
            act                    = ACT_JOIN;
            first                  = state_i.active_count;
            cnt                    = state_i.pending_change;
            state_o.pending_change = 7'd0;
            state_o.phase          = PH_IDLE;
          end
        end
        default: begin
          if (item_i.usage_valid) begin
            state_o.phase     = PH_IDLE;
            state_o.low_polls = polls_upd;
            if (item_i.usage_tenths > cfg_i.high_usage_threshold) begin
              if (grow_n != 7'd0) begin
                act                    = ACT_START;
                first                  = state_i.active_count;
                cnt                    = grow_n;
                state_o.pending_change = grow_n;
                state_o.phase          = PH_GROW;
              end
            end else if (polls_upd >= cfg_i.shrink_after_polls) begin
              state_o.low_polls = 8'd0;
              if (shrink_ok) begin
                state_o.active_count   = active_m1;
                state_o.pending_change = 7'd1;
                state_o.phase          = PH_SHRINK;
                act                    = ACT_STOP;
                first                  = active_m1;
                cnt                    = 7'd1;
              end
            end
          end
        end
      endcase
    end

    result_o.action         = act;
    result_o.first_index    = first[5:0];
    result_o.action_count   = cnt;
    result_o.active_workers = state_o.active_count;
    result_o.pool_phase     = state_o.phase;
    result_o.low_load_count = state_o.low_polls;
  end

endmodule

`default_nettype wire

// File: dv/worker_pool_autoscaler_core_tb.sv
// ----------------------------------------------------------------------------
// Worker pool autoscaler core testbench
// Drives start requests and usage polls through the valid/ready input
// channel under several register settings. A cycle-free predictor of the
// scaler works out each decision beat, and every result beat is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module worker_pool_autoscaler_core_tb;
  import wpa_pkg::*;

  // No-progress limit: longest legal quiet stretch is a register update
  // plus both sides idling, far below this.
  localparam int unsigned StallLimit  = 400;
  // Extra cycles after the last result before touching registers.
  localparam int unsigned DrainSlack  = 4;
  // Only the first few mismatches are printed in full.
  localparam int unsigned ReportLimit = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [9:0] cfg_data_i;

  wpa_in_if  req_ch ();
  wpa_out_if dec_ch ();

  worker_pool_autoscaler_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (req_ch),
    .result_o    (dec_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the pool.
  // --------------------------------------------------------------------------
  wpa_cfg_t    cfg_m;
  phase_e      phase_m;
  logic [6:0]  active_m;
  logic [6:0]  pending_m;
  logic [7:0]  low_polls_m;

  wpa_result_t decision_q[$];   // predicted decisions, oldest first

  bit          steady;          // when set, neither side inserts idle cycles
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned starts_seen;
  int unsigned stops_seen;
  int unsigned joins_seen;
  int unsigned cfg_sets;

  wpa_item_t   beat_req;
  wpa_result_t beat_dec;
  wpa_result_t want_dec;

  // Work out the decision for one accepted beat and advance the pool.
  function automatic wpa_result_t scale_decision(wpa_item_t it);
    wpa_result_t r;
    int unsigned cap;
    int unsigned room;
    int unsigned grant;
    int unsigned usage;
    int unsigned act;
    bit          want_start;
    r          = '0;
    want_start = 1'b0;
    grant      = 0;
    usage      = it.usage_tenths;
    cap        = (cfg_m.max_workers < MaxSlots) ? cfg_m.max_workers : MaxSlots;
    // A limit lowered below the pool leaves no free slots at all.
    room       = (cap > active_m) ? cap - active_m : 0;

    if (it.command == CMD_START) begin
      grant      = (it.request_count < room) ? it.request_count : room;
      want_start = 1'b1;
    end else begin
      case (phase_m)
        PH_GROW: begin
          // Hold until every new worker reports running.
          if (it.new_workers_running) begin
            active_m  = active_m + pending_m;
            pending_m = '0;
            phase_m   = PH_IDLE;
          end
        end
        PH_SHRINK: begin
          // Hold until the leaving worker has stopped, then join it.
          if (it.leaving_workers_stopped) begin
            r.action       = ACT_JOIN;
            r.first_index  = active_m[5:0];
            r.action_count = pending_m;
            pending_m      = '0;
            phase_m        = PH_IDLE;
          end
        end
        default: begin
          if (it.usage_valid) begin
            phase_m = PH_IDLE;
            if (usage > cfg_m.low_usage_threshold) begin
              low_polls_m = '0;
            end else if (low_polls_m != 8'hFF) begin
              low_polls_m = low_polls_m + 8'd1;
            end
            act = active_m;
            if (usage > cfg_m.high_usage_threshold) begin
              // Grow by half the pool, rounded up, within the step limit.
              grant = (cfg_m.grow_step_limit < (act + 1) / 2) ?
                      cfg_m.grow_step_limit : (act + 1) / 2;
              if (grant > room) grant = room;
              want_start = 1'b1;
            end else if (low_polls_m >= cfg_m.shrink_after_polls) begin
              low_polls_m = '0;
              if (act >= 2 && usage * act < cfg_m.shrink_ceiling * (act - 1)) begin
                active_m       = active_m - 7'd1;
                pending_m      = 7'd1;
                phase_m        = PH_SHRINK;
                r.action       = ACT_STOP;
                r.first_index  = active_m[5:0];
                r.action_count = 7'd1;
              end
            end
          end
        end
      endcase
    end

    // Requests outside idle and zero-size grants fall through as no action.
    if (want_start && phase_m == PH_IDLE && grant != 0) begin
      r.action       = ACT_START;
      r.first_index  = active_m[5:0];
      r.action_count = 7'(grant);
      pending_m      = 7'(grant);
      phase_m        = PH_GROW;
    end

    r.active_workers = active_m;
    r.pool_phase     = phase_m;
    r.low_load_count = low_polls_m;
    return r;
  endfunction

  function automatic wpa_item_t make_poll(bit uvalid, int unsigned usage, bit running,
                                          bit stopped);
    wpa_item_t it;
    it                         = '0;
    it.command                 = CMD_POLL;
    it.usage_valid             = uvalid;
    it.usage_tenths            = 10'(usage);
    it.new_workers_running     = running;
    it.leaving_workers_stopped = stopped;
    return it;
  endfunction

  function automatic wpa_item_t make_start(int unsigned count);
    wpa_item_t it;
    it               = '0;
    it.command       = CMD_START;
    it.request_count = 7'(count);
    return it;
  endfunction

  function automatic wpa_cfg_t make_cfg(int unsigned max_w, int unsigned low_u,
                                        int unsigned high_u, int unsigned ceil_u,
                                        int unsigned polls, int unsigned step);
    wpa_cfg_t c;
    c.max_workers          = 7'(max_w);
    c.low_usage_threshold  = 10'(low_u);
    c.high_usage_threshold = 10'(high_u);
    c.shrink_ceiling       = 10'(ceil_u);
    c.shrink_after_polls   = 8'(polls);
    c.grow_step_limit      = 7'(step);
    return c;
  endfunction

  function automatic wpa_cfg_t random_cfg();
    return make_cfg($urandom_range(1, 64), $urandom_range(0, 1000),
                    $urandom_range(0, 1000), $urandom_range(0, 1000),
                    $urandom_range(1, 6), $urandom_range(1, 64));
  endfunction

  // Mostly well-formed traffic: usage clustered around the thresholds so
  // both growth and shrink fire, acknowledgements usually present, and some
  // out-of-range counts and usages mixed in.
  function automatic wpa_item_t random_item();
    wpa_item_t   it;
    int unsigned usage;
    int unsigned hi_floor;
    hi_floor = cfg_m.high_usage_threshold + 1;
    case ($urandom_range(0, 2))
      0:       usage = $urandom_range(0, cfg_m.low_usage_threshold);
      1:       usage = $urandom_range(hi_floor, 1023);
      default: usage = $urandom_range(0, 1023);
    endcase
    it = make_poll($urandom_range(0, 9) != 0, usage, $urandom_range(0, 9) < 6,
                   $urandom_range(0, 9) < 6);
    if ($urandom_range(0, 3) == 0) begin
      it.command       = CMD_START;
      it.request_count = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(65, 127)) :
                                                       7'($urandom_range(0, 64));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("timeout: no beat moved for %0d cycles", StallLimit);
    $display("worker_pool_autoscaler_core: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: random back-pressure per beat, none while steady is set.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    dec_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        dec_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      dec_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!dec_ch.valid) @(posedge clk_i);
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("result %0d: %s expected %0d got %0d", beats_out, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: compare result beats first, then predict for the request beat
  // taken on the same edge. Both channels are sampled pre-edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (dec_ch.valid && dec_ch.ready) begin
        beats_out++;
        beat_dec.action         = dec_ch.action;
        beat_dec.first_index    = dec_ch.first_index;
        beat_dec.action_count   = dec_ch.action_count;
        beat_dec.active_workers = dec_ch.active_workers;
        beat_dec.pool_phase     = dec_ch.pool_phase;
        beat_dec.low_load_count = dec_ch.low_load_count;
        if (decision_q.size() == 0) begin
          report_mismatch("beat with no prediction outstanding, action",
                          beat_dec.action, 0);
        end else begin
          want_dec = decision_q.pop_front();
          if (beat_dec.action != want_dec.action)
            report_mismatch("action", beat_dec.action, want_dec.action);
          if (beat_dec.first_index != want_dec.first_index)
            report_mismatch("first_index", beat_dec.first_index, want_dec.first_index);
          if (beat_dec.action_count != want_dec.action_count)
            report_mismatch("action_count", beat_dec.action_count, want_dec.action_count);
          if (beat_dec.active_workers != want_dec.active_workers)
            report_mismatch("active_workers", beat_dec.active_workers,
                            want_dec.active_workers);
          if (beat_dec.pool_phase != want_dec.pool_phase)
            report_mismatch("pool_phase", beat_dec.pool_phase, want_dec.pool_phase);
          if (beat_dec.low_load_count != want_dec.low_load_count)
            report_mismatch("low_load_count", beat_dec.low_load_count,
                            want_dec.low_load_count);
        end
      end

      if (req_ch.valid && req_ch.ready) begin
        beats_in++;
        beat_req.command                 = req_ch.command;
        beat_req.request_count           = req_ch.request_count;
        beat_req.usage_valid             = req_ch.usage_valid;
        beat_req.usage_tenths            = req_ch.usage_tenths;
        beat_req.new_workers_running     = req_ch.new_workers_running;
        beat_req.leaving_workers_stopped = req_ch.leaving_workers_stopped;
        want_dec = scale_decision(beat_req);
        case (want_dec.action)
          ACT_START: starts_seen++;
          ACT_STOP:  stops_seen++;
          ACT_JOIN:  joins_seen++;
          default:   ;
        endcase
        decision_q.push_back(want_dec);
      end

      if ((dec_ch.valid && dec_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one request beat after a random gap and hold it until taken.
  task automatic send_item(wpa_item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid                   <= 1'b1;
    req_ch.command                 <= it.command;
    req_ch.request_count           <= it.request_count;
    req_ch.usage_valid             <= it.usage_valid;
    req_ch.usage_tenths            <= it.usage_tenths;
    req_ch.new_workers_running     <= it.new_workers_running;
    req_ch.leaving_workers_stopped <= it.leaving_workers_stopped;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold off until every predicted decision has come back.
  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (decision_q.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [9:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  // Write all six registers back to back, only once the pool is quiet.
  task automatic apply_config(wpa_cfg_t c);
    wait_results_done();
    write_reg(REG_MAX_WORKERS,  10'(c.max_workers));
    write_reg(REG_LOW_USAGE,    c.low_usage_threshold);
    write_reg(REG_HIGH_USAGE,   c.high_usage_threshold);
    write_reg(REG_SHRINK_CEIL,  c.shrink_ceiling);
    write_reg(REG_SHRINK_POLLS, 10'(c.shrink_after_polls));
    write_reg(REG_GROW_STEP,    10'(c.grow_step_limit));
    cfg_we_i <= 1'b0;
    cfg_m = c;
    cfg_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty pool and a pool of one: no shrink may fire. Also covers invalid
  // usage, a zero-size start, a request while growing and a missing ack.
  task automatic test_empty_pool();
    apply_config(make_cfg(16, 1000, 1000, 1000, 1, 10));
    send_item(make_poll(1'b1, 0, 1'b0, 1'b0));    // low-load trips, pool empty
    send_item(make_poll(1'b0, 1023, 1'b1, 1'b1)); // usage not measured
    send_item(make_start(0));
    send_item(make_start(1));
    send_item(make_start(5));                     // ignored while growing
    send_item(make_poll(1'b1, 0, 1'b0, 1'b1));    // no running ack yet
    send_item(make_poll(1'b0, 0, 1'b1, 1'b0));
    send_item(make_poll(1'b1, 0, 1'b0, 0));       // pool of one stays
  endtask

  // Usage-driven growth in half-pool steps, a start capped by free slots,
  // a full pool, then the limit dropped below the current pool size.
  task automatic test_growth_and_limit();
    apply_config(make_cfg(64, 500, 900, 700, 30, 64));
    send_item(make_start(3));
    send_item(make_poll(1'b0, 0, 1'b1, 1'b0));
    send_item(make_poll(1'b1, 1000, 1'b0, 1'b0));
    send_item(make_poll(1'b0, 0, 1'b1, 1'b0));
    send_item(make_poll(1'b1, 1023, 1'b0, 1'b0));
    send_item(make_poll(1'b0, 0, 1'b1, 1'b0));
    send_item(make_start(127));                   // capped to the free slots
    send_item(make_poll(1'b0, 0, 1'b1, 1'b0));
    send_item(make_poll(1'b1, 1023, 1'b0, 1'b0)); // full, nothing to add
    send_item(make_start(1));
    apply_config(make_cfg(1, 500, 900, 700, 30, 64));
    send_item(make_start(64));
    send_item(make_poll(1'b1, 1023, 1'b0, 1'b0));
  endtask

  // Stop one worker out of the full pool, ignore a request mid-shrink,
  // wait for the stop ack, then a poll whose projected usage sits exactly
  // at the ceiling (620 * 63 against 630 * 62) and must not stop another.
  task automatic test_shrink_handshake();
    apply_config(make_cfg(64, 1000, 1000, 630, 1, 4));
    send_item(make_poll(1'b1, 0, 1'b0, 1'b0));
    send_item(make_start(4));
    send_item(make_poll(1'b1, 0, 1'b1, 1'b0));
    send_item(make_poll(1'b0, 0, 1'b0, 1'b1));
    send_item(make_poll(1'b1, 620, 1'b0, 1'b0));
  endtask

  // High threshold at zero routes every counted poll down the growth path
  // with no free slots, so the low-load count climbs and must stick at 255.
  task automatic test_low_load_saturation();
    apply_config(make_cfg(1, 1000, 0, 0, 255, 1));
    repeat (260) begin
      send_item(make_poll(1'b1, $urandom_range(1, 1000),
                          $urandom_range(0, 1), $urandom_range(0, 1)));
    end
  endtask

  // Random traffic under one register setting, with the odd full drain.
  task automatic test_random_traffic(wpa_cfg_t c, int unsigned count);
    apply_config(c);
    repeat (count) begin
      if ($urandom_range(0, 15) == 0) wait_results_done();
      send_item(random_item());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni                         <= 1'b0;
    cfg_we_i                       <= 1'b0;
    cfg_index_i                    <= REG_MAX_WORKERS;
    cfg_data_i                     <= '0;
    req_ch.valid                   <= 1'b0;
    req_ch.command                 <= CMD_POLL;
    req_ch.request_count           <= '0;
    req_ch.usage_valid             <= 1'b0;
    req_ch.usage_tenths            <= '0;
    req_ch.new_workers_running     <= 1'b0;
    req_ch.leaving_workers_stopped <= 1'b0;
    steady       = 1'b0;
    beats_in     = 0;
    beats_out    = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    starts_seen  = 0;
    stops_seen   = 0;
    joins_seen   = 0;
    cfg_sets     = 0;
    // Predictor comes out of reset with the block's register defaults.
    cfg_m        = make_cfg(16, 500, 900, 700, 30, 10);
    phase_m      = PH_IDLE;
    active_m     = '0;
    pending_m    = '0;
    low_polls_m  = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pool();
    test_growth_and_limit();
    test_shrink_handshake();
    test_low_load_saturation();
    test_random_traffic(make_cfg(64, 600, 800, 900, 2, 4), 40);
    test_random_traffic(random_cfg(), 40);
    steady = 1'b1;   // back-to-back stretch on both sides
    test_random_traffic(make_cfg(64, 0, 0, 1000, 1, 64), 40);
    steady = 1'b0;
    test_random_traffic(random_cfg(), 40);

    wait_results_done();
    repeat (10) @(posedge clk_i);

    if (decision_q.size() != 0) begin
      $display("%0d predicted decisions never arrived", decision_q.size());
      mismatches += decision_q.size();
    end
    $display("covered %0d request beats and %0d decision beats over %0d register sets",
             beats_in, beats_out, cfg_sets);
    $display("decisions: %0d starts, %0d stops, %0d joins; %0d field mismatches",
             starts_seen, stops_seen, joins_seen, mismatches);
    if (mismatches == 0) begin
      $display("worker_pool_autoscaler_core: match");
    end else begin
      $display("worker_pool_autoscaler_core: mismatch");
    end
    $finish;
  end

endmodule
